/* rtl/rdg_pkg.sv */
// Package for the Rasch difficulty gradient unit: widths, queue entry type,
// configuration register indexes and constant tables for the exp series.
// No dependencies.
package rdg_pkg;

  // Configuration port
  localparam int unsigned CfgIdxW  = 1;
  localparam int unsigned CfgDataW = 16;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_SCALE = 1'b0,
    CFG_CLAMP = 1'b1
  } cfg_idx_e;

  localparam logic [15:0] ScaleRst = 16'd4096;
  localparam logic [14:0] ClampRst = 15'd32767;

  // Stream payload widths
  localparam int unsigned InDataW  = 96;
  localparam int unsigned OutDataW = 48;
  localparam int unsigned SumW     = 48;

  // One classified term on its way from the front to the back
  typedef struct packed {
    logic [14:0] m;        // clamped exponent magnitude, Q3.12
    logic        neg;      // exponent is negative (and nonzero)
    logic [31:0] count;    // Q16.16
    logic [31:0] correct;  // Q16.16
    logic        last;
  } entry_t;

  // Term queue
  localparam int unsigned QDepth = 4;
  localparam int unsigned QPtrW  = 2;
  localparam int unsigned QCntW  = 3;

  // exp(-x) series, all values Q1.30
  localparam int unsigned Q30W     = 31;
  localparam logic [30:0] Q30One   = 31'h4000_0000;
  localparam logic [30:0] Q30Half  = 31'h2000_0000;
  localparam logic [30:0] E1Q30    = 31'd395007543;  // truncated series at f = 1.0
  localparam logic [3:0]  LastKIdx = 4'd13;          // fourteen series terms

  // floor((2^32-1)/k) for k = kidx+1; one correction step restores exact floor
  function automatic logic [31:0] recip_f(input logic [3:0] kidx);
    logic [31:0] r;
    case (kidx)
      4'd0:    r = 32'd4294967295;
      4'd1:    r = 32'd2147483647;
      4'd2:    r = 32'd1431655765;
      4'd3:    r = 32'd1073741823;
      4'd4:    r = 32'd858993459;
      4'd5:    r = 32'd715827882;
      4'd6:    r = 32'd613566756;
      4'd7:    r = 32'd536870911;
      4'd8:    r = 32'd477218588;
      4'd9:    r = 32'd429496729;
      4'd10:   r = 32'd390451572;
      4'd11:   r = 32'd357913941;
      4'd12:   r = 32'd330382099;
      4'd13:   r = 32'd306783378;
      default: r = 32'd0;
    endcase
    return r;
  endfunction

  // Probability divider
  localparam int unsigned DivNumW = 48;
  localparam int unsigned DivDenW = 32;
  localparam int unsigned QuoW    = 17;
  localparam logic [47:0] Q46One  = 48'h4000_0000_0000;

  // Running sum limits
  localparam logic signed [47:0] SumMax = 48'sh7FFF_FFFF_FFFF;
  localparam logic signed [47:0] SumMin = 48'sh8000_0000_0000;

endpackage

/* rtl/rasch_difficulty_gradient_unit.sv */
// Rasch difficulty gradient unit: top level with config registers and the stream ports.
// A term goes from the front register through the term queue to the back engine, which runs the
// exp series on the exponent fraction, one exp(-1) multiply per unit of its integer part n (0..7),
// then the divider; a result is output on the last term of an item.
// The back engine takes a new term only when its pass is done; a 4-entry queue buffers the front.
// Reset (rst_ni, async low) clears the running sum, queue and control; scale=1.0, clamp=max.
module rasch_difficulty_gradient_unit import rdg_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // [15:0] ability, [31:16] difficulty, [63:32] node_count, [95:64] node_correct
  input  logic [InDataW-1:0]  s_axis_tdata,
  input  logic                s_axis_tlast,   // last_node
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // [47:0] gradient_value
  output logic [OutDataW-1:0] m_axis_tdata,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i
);

  logic [15:0]      scale_d, scale_q;
  logic [14:0]      clamp_d, clamp_q;
  logic             f_push_valid;
  logic             q_push_ready;
  entry_t           f_entry;
  logic             q_pop_valid;
  logic             b_pop_ready;
  entry_t           q_entry;
  logic [QCntW-1:0] q_fill;
  logic             b_sum_zero;

  // Configuration writes
  always_comb begin
    scale_d = scale_q;
    clamp_d = clamp_q;
    if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_SCALE: scale_d = cfg_wdata_i;
        CFG_CLAMP: clamp_d = cfg_wdata_i[14:0];
        default:   scale_d = scale_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scale_q <= ScaleRst;
      clamp_q <= ClampRst;
    end else begin
      scale_q <= scale_d;
      clamp_q <= clamp_d;
    end
  end

  rdg_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .ability_i    (s_axis_tdata[15:0]),
    .difficulty_i (s_axis_tdata[31:16]),
    .count_i      (s_axis_tdata[63:32]),
    .correct_i    (s_axis_tdata[95:64]),
    .last_i       (s_axis_tlast),
    .scale_i      (scale_q),
    .clamp_i      (clamp_q),
    .push_valid_o (f_push_valid),
    .push_ready_i (q_push_ready),
    .push_entry_o (f_entry)
  );

  rdg_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (f_push_valid),
    .push_ready_o (q_push_ready),
    .push_entry_i (f_entry),
    .pop_valid_o  (q_pop_valid),
    .pop_ready_i  (b_pop_ready),
    .pop_entry_o  (q_entry),
    .fill_o       (q_fill)
  );

  rdg_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_valid_i (q_pop_valid),
    .pop_ready_o (b_pop_ready),
    .pop_entry_i (q_entry),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata),
    .sum_zero_o  (b_sum_zero)
  );

`ifndef NO_ASSERTIONS
  // Queue fill never exceeds its depth
  a_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_fill <= QCntW'(QDepth))
    else $error("term queue overfilled");

  // Input stalls only when the front entry is blocked by a full queue
  a_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> (f_push_valid && !q_push_ready))
    else $error("input stalled without back pressure");

  // A new result always comes with the running sum cleared
  a_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> b_sum_zero)
    else $error("running sum not cleared on result");
`endif

endmodule

/* rtl/rdg_front.sv */
// Front stage: takes one term per transfer, forms the clamped exponent
// magnitude and its sign, and holds the classified entry for the queue. Uses rdg_pkg.
module rdg_front import rdg_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [15:0] ability_i,
  input  logic [15:0] difficulty_i,
  input  logic [31:0] count_i,
  input  logic [31:0] correct_i,
  input  logic        last_i,
  input  logic [15:0] scale_i,
  input  logic [14:0] clamp_i,
  output logic        push_valid_o,
  input  logic        push_ready_i,
  output entry_t      push_entry_o
);

  logic [16:0] diff;
  logic [16:0] abs_diff;
  logic [32:0] mag;
  logic [33:0] mag_rnd;
  logic [21:0] m_raw;
  logic [14:0] m_clamp;
  logic        accept;
  logic        valid_d, valid_q;
  entry_t      entry_d, entry_q;

  // Scaled difference, magnitude rounded half away from zero, then clamped
  assign diff     = {ability_i[15], ability_i} - {difficulty_i[15], difficulty_i};
  assign abs_diff = diff[16] ? (17'd0 - diff) : diff;
  assign mag      = 33'(abs_diff) * 33'(scale_i);
  assign mag_rnd  = {1'b0, mag} + 34'd2048;
  assign m_raw    = mag_rnd[33:12];
  assign m_clamp  = (m_raw > {7'd0, clamp_i}) ? clamp_i : m_raw[14:0];

  assign in_ready_o = !valid_q || push_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    entry_d.m       = m_clamp;
    entry_d.neg     = diff[16] && (m_clamp != 15'd0);
    entry_d.count   = count_i;
    entry_d.correct = correct_i;
    entry_d.last    = last_i;
  end

  // Hold the entry until the queue takes it
  always_comb begin
    valid_d = valid_q;
    if (accept) begin
      valid_d = 1'b1;
    end else if (push_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      entry_q <= entry_d;
    end
  end

  assign push_valid_o = valid_q;
  assign push_entry_o = entry_q;

endmodule

/* rtl/rdg_fifo.sv */
// Short term queue between the front stage and the back engine.
// Uses rdg_pkg for the entry type and depth.
module rdg_fifo import rdg_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_valid_i,
  output logic             push_ready_o,
  input  entry_t           push_entry_i,
  output logic             pop_valid_o,
  input  logic             pop_ready_i,
  output entry_t           pop_entry_o,
  output logic [QCntW-1:0] fill_o
);

  entry_t           mem_q [QDepth];
  logic [QPtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCntW-1:0] cnt_d, cnt_q;
  logic             push, pop;

  assign push_ready_o = (cnt_q != QCntW'(QDepth));
  assign pop_valid_o  = (cnt_q != '0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_entry_o  = mem_q[rd_ptr_q];
  assign fill_o       = cnt_q;

  always_comb begin
    cnt_d = cnt_q;
    if (push && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_entry_i;
    end
  end

endmodule

/* rtl/rdg_exp.sv */
// Iterative exp(-m) unit, Q1.30 result: fourteen truncated series terms on
// the fraction, then one multiply by exp(-1) per integer unit. Uses rdg_pkg.
module rdg_exp import rdg_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic [14:0]     m_i,
  output logic            done_o,
  output logic [Q30W-1:0] t_o
);

  typedef enum logic [5:0] {
    EX_IDLE = 6'b000001,
    EX_MUL  = 6'b000010,
    EX_RCP  = 6'b000100,
    EX_COR  = 6'b001000,
    EX_PMUL = 6'b010000,
    EX_PRND = 6'b100000
  } ex_state_e;

  ex_state_e          state_d, state_q;
  logic [11:0]        f_d, f_q;
  logic [2:0]         n_d, n_q;
  logic [3:0]         kidx_d, kidx_q;
  logic [Q30W-1:0]    term_d, term_q;
  logic [Q30W-1:0]    x_d, x_q;
  logic [Q30W-1:0]    r_d, r_q;
  logic signed [31:0] sum_d, sum_q;
  logic [62:0]        prod_d, prod_q;
  logic               done_d, done_q;

  logic [3:0]         kval;
  logic [Q30W-1:0]    q0;
  logic [34:0]        q0k;
  logic [34:0]        rem;
  logic [Q30W-1:0]    qv;
  logic signed [31:0] sum_nx;
  logic [62:0]        rnd;

  // Reciprocal quotient and its one-step correction
  assign kval   = kidx_q + 4'd1;
  assign q0     = prod_q[62:32];
  assign q0k    = 35'(q0) * 35'(kval);
  assign rem    = 35'(x_q) - q0k;
  assign qv     = q0 + Q30W'(rem >= 35'(kval));
  assign sum_nx = kidx_q[0] ? (sum_q + signed'({1'b0, qv})) : (sum_q - signed'({1'b0, qv}));
  assign rnd    = prod_q + 63'(Q30Half);

  always_comb begin
    state_d = state_q;
    f_d     = f_q;
    n_d     = n_q;
    kidx_d  = kidx_q;
    term_d  = term_q;
    x_d     = x_q;
    r_d     = r_q;
    sum_d   = sum_q;
    prod_d  = prod_q;
    done_d  = 1'b0;
    case (state_q)
      EX_IDLE: begin
        if (start_i) begin
          f_d     = m_i[11:0];
          n_d     = m_i[14:12];
          kidx_d  = '0;
          term_d  = Q30One;
          sum_d   = signed'({1'b0, Q30One});
          state_d = EX_MUL;
        end
      end
      // term * f
      EX_MUL: begin
        prod_d  = 63'(term_q) * 63'(f_q);
        state_d = EX_RCP;
      end
      // drop the 4096 and multiply by the reciprocal of k
      EX_RCP: begin
        x_d     = prod_q[42:12];
        prod_d  = 63'(prod_q[42:12]) * 63'(recip_f(kidx_q));
        state_d = EX_COR;
      end
      // exact floor, fold into the alternating sum
      EX_COR: begin
        term_d = qv;
        sum_d  = sum_nx;
        if (kidx_q == LastKIdx) begin
          r_d = sum_nx[31] ? '0 : sum_nx[30:0];
          if (n_q == '0) begin
            done_d  = 1'b1;
            state_d = EX_IDLE;
          end else begin
            state_d = EX_PMUL;
          end
        end else begin
          kidx_d  = kidx_q + 4'd1;
          state_d = EX_MUL;
        end
      end
      EX_PMUL: begin
        prod_d  = 63'(r_q) * 63'(E1Q30);
        state_d = EX_PRND;
      end
      EX_PRND: begin
        r_d = rnd[60:30];
        n_d = n_q - 3'd1;
        if (n_q == 3'd1) begin
          done_d  = 1'b1;
          state_d = EX_IDLE;
        end else begin
          state_d = EX_PMUL;
        end
      end
      default: begin
        state_d = EX_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= EX_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    f_q    <= f_d;
    n_q    <= n_d;
    kidx_q <= kidx_d;
    term_q <= term_d;
    x_q    <= x_d;
    r_q    <= r_d;
    sum_q  <= sum_d;
    prod_q <= prod_d;
  end

  assign done_o = done_q;
  assign t_o    = r_q;

endmodule

/* rtl/rdg_div.sv */
// Restoring divider, one quotient bit per cycle, for the logistic probability.
// Uses rdg_pkg for widths.
module rdg_div import rdg_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [DivNumW-1:0] num_i,
  input  logic [DivDenW-1:0] den_i,
  output logic               done_o,
  output logic [QuoW-1:0]    quo_o
);

  logic               busy_q;
  logic               done_q;
  logic [4:0]         cnt_q;
  logic [DivNumW-1:0] rem_q;
  logic [DivNumW-1:0] dsh_q;
  logic [QuoW-1:0]    quo_q;
  logic               ge;

  assign ge = (rem_q >= dsh_q);

  // Control: count down from the top quotient bit
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i && !busy_q) begin
        busy_q <= 1'b1;
        cnt_q  <= 5'(QuoW - 1);
      end else if (busy_q) begin
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          cnt_q <= cnt_q - 5'd1;
        end
      end
    end
  end

  // Datapath: compare, subtract, shift divisor down
  always_ff @(posedge clk_i) begin
    if (start_i && !busy_q) begin
      rem_q <= num_i;
      dsh_q <= {den_i, 16'd0};
      quo_q <= '0;
    end else if (busy_q) begin
      if (ge) begin
        rem_q <= rem_q - dsh_q;
      end
      quo_q <= {quo_q[QuoW-2:0], ge};
      dsh_q <= {1'b0, dsh_q[DivNumW-1:1]};
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule

/* rtl/rdg_back.sv */
// Back engine: pops one term, runs exp and divide, weights by the node count,
// accumulates with saturation and emits the negated sum on the last term.
// Uses rdg_pkg, rdg_exp and rdg_div.
module rdg_back import rdg_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                pop_valid_i,
  output logic                pop_ready_o,
  input  entry_t              pop_entry_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [OutDataW-1:0] out_data_o,
  output logic                sum_zero_o
);

  typedef enum logic [4:0] {
    BK_IDLE = 5'b00001,
    BK_EXP  = 5'b00010,
    BK_DIV  = 5'b00100,
    BK_MUL  = 5'b01000,
    BK_ACC  = 5'b10000
  } bk_state_e;

  bk_state_e           state_d, state_q;
  entry_t              entry_q;
  logic [15:0]         p_q;
  logic [47:0]         prod_q;
  logic signed [47:0]  sum_d, sum_q;
  logic                oval_d, oval_q;
  logic [OutDataW-1:0] odata_q;

  logic                exp_start, exp_done;
  logic [Q30W-1:0]     exp_t;
  logic                div_start, div_done;
  logic [DivDenW-1:0]  den;
  logic [DivNumW-1:0]  num;
  logic [QuoW-1:0]     quo;

  logic [48:0]         exp_rnd;
  logic [32:0]         expected;
  logic signed [33:0]  term;
  logic signed [48:0]  s_wide;
  logic signed [47:0]  s_sat;
  logic signed [47:0]  grad;
  logic                out_free;
  logic                acc_go;

  rdg_exp u_exp (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (exp_start),
    .m_i     (pop_entry_i.m),
    .done_o  (exp_done),
    .t_o     (exp_t)
  );

  rdg_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (num),
    .den_i   (den),
    .done_o  (div_done),
    .quo_o   (quo)
  );

  assign pop_ready_o = (state_q == BK_IDLE);
  assign exp_start   = (state_q == BK_IDLE) && pop_valid_i;
  assign div_start   = (state_q == BK_EXP) && exp_done;

  // Probability operands, rounded quotient
  assign den = {1'b0, Q30One} + {1'b0, exp_t};
  assign num = entry_q.neg ? (DivNumW'({exp_t, 16'd0}) + DivNumW'(den[31:1]))
                           : (Q46One + DivNumW'(den[31:1]));

  // Term and saturating accumulate
  assign exp_rnd  = {1'b0, prod_q} + 49'd32768;
  assign expected = exp_rnd[48:16];
  assign term     = signed'({2'b00, entry_q.correct}) - signed'({1'b0, expected});
  assign s_wide   = 49'(sum_q) + 49'(term);
  assign s_sat    = (s_wide[48] != s_wide[47]) ? (s_wide[48] ? SumMin : SumMax)
                                               : s_wide[47:0];
  assign grad     = (s_sat == SumMin) ? SumMax : -s_sat;

  assign out_free = !oval_q || out_ready_i;
  assign acc_go   = !entry_q.last || out_free;

  always_comb begin
    state_d = state_q;
    sum_d   = sum_q;
    oval_d  = oval_q && !out_ready_i;
    case (state_q)
      BK_IDLE: begin
        if (pop_valid_i) begin
          state_d = BK_EXP;
        end
      end
      BK_EXP: begin
        if (exp_done) begin
          state_d = BK_DIV;
        end
      end
      BK_DIV: begin
        if (div_done) begin
          state_d = BK_MUL;
        end
      end
      BK_MUL: begin
        state_d = BK_ACC;
      end
      // hold here while a last term waits for the output register
      BK_ACC: begin
        if (acc_go) begin
          state_d = BK_IDLE;
          if (entry_q.last) begin
            sum_d  = '0;
            oval_d = 1'b1;
          end else begin
            sum_d = s_sat;
          end
        end
      end
      default: begin
        state_d = BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= BK_IDLE;
      sum_q   <= '0;
      oval_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      sum_q   <= sum_d;
      oval_q  <= oval_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (exp_start) begin
      entry_q <= pop_entry_i;
    end
    if ((state_q == BK_DIV) && div_done) begin
      p_q <= quo[16] ? 16'hFFFF : quo[15:0];
    end
    if (state_q == BK_MUL) begin
      prod_q <= 48'(entry_q.count) * 48'(p_q);
    end
    if ((state_q == BK_ACC) && entry_q.last && out_free) begin
      odata_q <= grad;
    end
  end

  assign out_valid_o = oval_q;
  assign out_data_o  = odata_q;
  assign sum_zero_o  = (sum_q == '0);

endmodule

/* dv/rasch_difficulty_gradient_unit_tb.sv */
// Self-checking bench for rasch_difficulty_gradient_unit: drives node terms, predicts
// the per-item gradient in a scoreboard class and compares every output transfer.
// Depends on rdg_pkg and the unit's RTL only.
module rasch_difficulty_gradient_unit_tb;
  import rdg_pkg::*;

  typedef struct {
    logic signed [15:0] ability;
    logic signed [15:0] difficulty;
    logic [31:0]        count;
    logic [31:0]        correct;
    logic               last;
  } node_term_t;

  typedef enum int {
    IDLE_NONE,
    IDLE_SEND,
    IDLE_RECV,
    IDLE_BOTH
  } idle_mode_e;

  localparam int unsigned SeriesTerms = 14;
  localparam int unsigned SettleCycles = 600;   // queue plus one pass per queued term
  localparam int unsigned PhaseTerms = 225;

  // Track config, running sum and expected gradients; check output transfers
  class grad_tracker;
    logic [15:0] scale;
    logic [14:0] clamp;
    longint      sum;
    logic [47:0] grad_expected[$];
    int unsigned mismatches;

    function new();
      scale = ScaleRst;
      clamp = ClampRst;
      sum = 0;
      mismatches = 0;
    endfunction

    function void set_reg(cfg_idx_e idx, logic [15:0] val);
      if (idx == CFG_SCALE) begin
        scale = val;
      end else begin
        clamp = val[14:0];
      end
    endfunction

    // exp(-f/4096) in Q1.30 by a truncated alternating series
    function longint unsigned exp_series(longint unsigned f);
      longint acc;
      longint unsigned term;
      acc = 64'd1 << 30;
      term = 64'd1 << 30;
      for (int k = 1; k <= SeriesTerms; k++) begin
        term = term * f / (64'd4096 * k);
        if (k % 2) begin
          acc -= term;
        end else begin
          acc += term;
        end
      end
      if (acc < 0) acc = 0;
      return acc;
    endfunction

    function longint unsigned exp_neg(longint unsigned m);
      longint unsigned r;
      longint unsigned e1;
      int unsigned     n;
      r = exp_series(m & 4095);
      e1 = exp_series(4096);
      n = (m >> 12) & 7;
      while (n > 0) begin
        r = (r * e1 + (64'd1 << 29)) >> 30;
        n--;
      end
      return r;
    endfunction

    // Success probability in Q0.16
    function longint unsigned success_prob(logic signed [15:0] ab, logic signed [15:0] df);
      longint          d;
      bit              neg;
      longint unsigned mag;
      longint unsigned m;
      longint unsigned t;
      longint unsigned den;
      longint unsigned p;
      d = longint'(ab) - longint'(df);
      neg = d < 0;
      mag = longint'(neg ? -d : d) * longint'(scale);
      m = (mag + 2048) >> 12;
      if (m > clamp) m = clamp;
      if (m == 0) neg = 0;
      t = exp_neg(m);
      den = (64'd1 << 30) + t;
      if (neg) begin
        p = ((t << 16) + den / 2) / den;
      end else begin
        p = ((64'd1 << 46) + den / 2) / den;
      end
      if (p > 65535) p = 65535;
      return p;
    endfunction

    // Accumulate one accepted term; queue the gradient when it closes an item
    function void note_term(node_term_t nt);
      longint unsigned cnt;
      longint unsigned p;
      longint unsigned predicted;
      longint          s;
      longint          g;
      longint          hi;
      longint          lo;
      hi = SumMax;
      lo = SumMin;
      cnt = nt.count;
      p = success_prob(nt.ability, nt.difficulty);
      predicted = (cnt * p + 32768) >> 16;
      s = sum + (longint'(nt.correct) - longint'(predicted));
      if (s > hi) s = hi;
      if (s < lo) s = lo;
      sum = s;
      if (nt.last) begin
        g = (s == lo) ? hi : -s;
        grad_expected.push_back(g[47:0]);
        sum = 0;
      end
    endfunction

    function void check_gradient(logic [47:0] got);
      logic [47:0] want;
      if (grad_expected.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected gradient transfer: got %h", got);
        return;
      end
      want = grad_expected.pop_front();
      if (want !== got) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("gradient mismatch: expected %h got %h", want, got);
        end
      end
    endfunction

    function int unsigned pending();
      return grad_expected.size();
    endfunction
  endclass

  logic                clk_i;
  logic                rst_ni;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata;
  logic                s_axis_tlast;
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  logic [OutDataW-1:0] m_axis_tdata;
  logic                cfg_we_i;
  cfg_idx_e            cfg_idx_i;
  logic [CfgDataW-1:0] cfg_wdata_i;

  grad_tracker sb;
  idle_mode_e  idle_mode;

  rasch_difficulty_gradient_unit u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  initial clk_i = 1'b0;
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Bound the run
  initial begin
    #15_000_000;
    $display("tb: failure");
    $finish;
  end

  function automatic bit roll(int unsigned pct);
    return $urandom_range(99) < pct;
  endfunction

  function automatic int unsigned send_idle_pct();
    return (idle_mode == IDLE_SEND) ? 61 : (idle_mode == IDLE_BOTH) ? 9 : 0;
  endfunction

  function automatic int unsigned recv_stall_pct();
    return (idle_mode == IDLE_RECV) ? 61 : (idle_mode == IDLE_BOTH) ? 9 : 0;
  endfunction

  // Sink side: check each output transfer, then pick the next ready
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) sb.check_gradient(m_axis_tdata);
    m_axis_tready <= !roll(recv_stall_pct());
  end

  // Offer one term, hold it until the transfer, then note it
  task automatic send_term(node_term_t nt);
    while (roll(send_idle_pct())) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {nt.correct, nt.count, nt.difficulty, nt.ability};
    s_axis_tlast  <= nt.last;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    sb.note_term(nt);
  endtask

  // Wait for all gradients, then let queued non-last terms drain
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_regs(logic [15:0] scale, logic [15:0] clamp);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= CFG_SCALE;
    cfg_wdata_i <= scale;
    @(posedge clk_i);
    sb.set_reg(CFG_SCALE, scale);
    cfg_idx_i   <= CFG_CLAMP;
    cfg_wdata_i <= clamp;
    @(posedge clk_i);
    sb.set_reg(CFG_CLAMP, clamp);
    cfg_we_i    <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic node_term_t mk(int ab, int df, logic [31:0] cnt, logic [31:0] cor,
                                    bit last);
    node_term_t nt;
    nt.ability = ab[15:0];
    nt.difficulty = df[15:0];
    nt.count = cnt;
    nt.correct = cor;
    nt.last = last;
    return nt;
  endfunction

  function automatic logic [15:0] pick_q412();
    case ($urandom_range(7))
      0:       return 16'h8000;
      1:       return 16'h7FFF;
      2:       return 16'h0000;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [31:0] pick_q1616();
    case ($urandom_range(7))
      0:       return 32'h0000_0000;
      1:       return 32'hFFFF_FFFF;
      2, 3:    return $urandom;
      default: return $urandom_range(32'h0040_0000);
    endcase
  endfunction

  // Random stream: mostly whole items sharing one difficulty, some loose terms
  task automatic run_random(int unsigned n_terms);
    int unsigned sent;
    int unsigned len;
    logic [15:0] df;
    node_term_t  nt;
    sent = 0;
    while (sent < n_terms) begin
      if (roll(85)) begin
        len = $urandom_range(1, 12);
        df = pick_q412();
        for (int i = 0; i < len; i++) begin
          nt.difficulty = df;
          nt.ability = roll(50) ? pick_q412() : df + 16'($signed($urandom_range(8192)) - 4096);
          nt.count = pick_q1616();
          nt.correct = roll(50) ? pick_q1616() : nt.count >> $urandom_range(4);
          nt.last = (i == len - 1);
          send_term(nt);
        end
        sent += len;
      end else begin
        nt.ability = pick_q412();
        nt.difficulty = pick_q412();
        nt.count = pick_q1616();
        nt.correct = pick_q1616();
        nt.last = $urandom_range(1);
        send_term(nt);
        sent++;
      end
    end
  endtask

  task automatic run_phase(logic [15:0] scale, logic [15:0] clamp, idle_mode_e mode);
    settle();
    write_regs(scale, clamp);
    idle_mode = mode;
    run_random(PhaseTerms);
  endtask

  initial begin
    node_term_t directed[$];
    sb = new();
    idle_mode = IDLE_NONE;
    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tlast  <= 1'b0;
    m_axis_tready <= 1'b0;
    cfg_we_i      <= 1'b0;
    cfg_idx_i     <= CFG_SCALE;
    cfg_wdata_i   <= '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed terms at reset config: field extremes, rounding, integer exponent parts
    directed.push_back(mk(32767, -32768, 32'hFFFF_FFFF, 32'h0, 0));
    directed.push_back(mk(-32768, 32767, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1));
    directed.push_back(mk(0, 0, 32'h0001_0000, 32'h0, 1));
    directed.push_back(mk(0, 0, 32'h0, 32'hFFFF_FFFF, 1));
    directed.push_back(mk(1, 0, 32'h0001_0000, 32'h0000_8000, 0));
    directed.push_back(mk(0, 1, 32'h0001_0000, 32'h0000_8000, 1));
    directed.push_back(mk(4096, 0, 32'h0064_0000, 32'h0032_0000, 1));
    directed.push_back(mk(-4096, 0, 32'h0064_0000, 32'h0032_0000, 1));
    directed.push_back(mk(2047, 0, 32'h0010_0000, 32'h0, 0));
    directed.push_back(mk(2048, 0, 32'h0010_0000, 32'h0, 1));
    directed.push_back(mk(32767, 32767, 32'hFFFF_FFFF, 32'h8000_0000, 1));
    directed.push_back(mk(-32768, -32768, 32'h8000_0000, 32'h0, 1));
    directed.push_back(mk(8191, -8192, 32'h0123_4567, 32'h0, 1));
    directed.push_back(mk(-28672, 0, 32'h7FFF_FFFF, 32'h0000_0001, 0));
    directed.push_back(mk(12288, 0, 32'h0002_0000, 32'h0001_0000, 0));
    directed.push_back(mk(-12288, 0, 32'h0002_0000, 32'h0001_0000, 1));
    foreach (directed[i]) send_term(directed[i]);

    // Config sweep: reset values, zero scale, zero clamp, both at their maximum, and random settings
    run_phase(16'd4096, 16'd32767, IDLE_NONE);
    run_phase(16'd0, 16'($urandom_range(32767)), IDLE_SEND);
    run_phase(16'hFFFF, 16'hFFFF, IDLE_RECV);
    run_phase(16'($urandom), 16'h8000, IDLE_BOTH);
    run_phase(16'($urandom_range(8192)), 16'($urandom), IDLE_SEND);
    run_phase(16'($urandom), 16'($urandom_range(16384)), IDLE_RECV);

    settle();
    if (sb.mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
